>>> src/threshold_marching_squares_macros.svh
// ----------------------------------------------------------------------------
// Threshold marching squares: assertion macros
// Shared concurrent assertion shorthands, clocked on clk and reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_MARCHING_SQUARES_MACROS_SVH
`define THRESHOLD_MARCHING_SQUARES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tms_pkg.sv
// ----------------------------------------------------------------------------
// Threshold marching squares package
// Shared constants, register indexes, trace modes and the edge lookup.
// ----------------------------------------------------------------------------
package tms_pkg;

	// Default line store depth (grid points per row at most).
	localparam int MAX_GRID_WIDTH_DEF = 1024;
	// Largest number of grid rows per frame.
	localparam int GRID_HEIGHT_MAX = 1024;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TRACE_MODE  = 3'd0;
	localparam logic [2:0] CFG_THRESHOLD   = 3'd1;
	localparam logic [2:0] CFG_INVERT      = 3'd2;
	localparam logic [2:0] CFG_GRID_WIDTH  = 3'd3;
	localparam logic [2:0] CFG_GRID_HEIGHT = 3'd4;

	// Trace modes; the reserved code behaves as the any-channel mode.
	localparam logic [1:0] MODE_ALPHA = 2'd0;
	localparam logic [1:0] MODE_LUMA  = 2'd1;
	localparam logic [1:0] MODE_ANY   = 2'd2;

	// Edge codes.
	typedef logic [1:0] edge_t;
	localparam edge_t EDGE_TOP    = 2'd0;
	localparam edge_t EDGE_RIGHT  = 2'd1;
	localparam edge_t EDGE_BOTTOM = 2'd2;
	localparam edge_t EDGE_LEFT   = 2'd3;

	// Cases of note.
	localparam logic [3:0] CASE_EMPTY   = 4'd0;
	localparam logic [3:0] CASE_FULL    = 4'd15;
	localparam logic [3:0] CASE_SADDLE_A = 4'd5;
	localparam logic [3:0] CASE_SADDLE_B = 4'd10;

	localparam logic [2:0] COUNT_PAIR   = 3'd2;
	localparam logic [2:0] COUNT_SADDLE = 3'd4;

	// Edges crossed by a square, first edge in the lowest slot.
	typedef edge_t [3:0] edge_set_t;

	function automatic edge_set_t edge_lookup(input logic [3:0] cs);
		edge_set_t e;
		e = {4{EDGE_TOP}};
		unique case (cs)
			4'd1, 4'd14: begin
				e[0] = EDGE_LEFT;
				e[1] = EDGE_BOTTOM;
			end
			4'd2, 4'd13: begin
				e[0] = EDGE_BOTTOM;
				e[1] = EDGE_RIGHT;
			end
			4'd3, 4'd12: begin
				e[0] = EDGE_LEFT;
				e[1] = EDGE_RIGHT;
			end
			4'd4, 4'd11: begin
				e[0] = EDGE_TOP;
				e[1] = EDGE_RIGHT;
			end
			4'd6, 4'd9: begin
				e[0] = EDGE_TOP;
				e[1] = EDGE_BOTTOM;
			end
			4'd7, 4'd8: begin
				e[0] = EDGE_LEFT;
				e[1] = EDGE_TOP;
			end
			CASE_SADDLE_A, CASE_SADDLE_B: begin
				e[0] = EDGE_TOP;
				e[1] = EDGE_RIGHT;
				e[2] = EDGE_BOTTOM;
				e[3] = EDGE_LEFT;
			end
			default: begin
				e = {4{EDGE_TOP}};
			end
		endcase
		return e;
	endfunction

endpackage

>>> src/tms_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tms_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = tms_pkg::MAX_GRID_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> src/threshold_marching_squares.sv
// ----------------------------------------------------------------------------
// Threshold marching squares
// Thresholds a raster stream of RGBA grid points and emits the marching
// squares case and crossed edges of every mixed 2x2 square.
// ----------------------------------------------------------------------------
// One grid point is taken per cycle and a result, if the point closes a mixed
// square, appears in the output register in the next cycle; sustained rate is
// one point per clock while the output side keeps up. The previous row lives
// in a one-bit line store of MAX_GRID_WIDTH entries with a registered read
// port; it is read one column ahead so the bit above each point is waiting
// when the point arrives. The line store needs no clearing pass after reset.
// Results: square_x, square_y, case_index (tl=8 tr=4 br=2 bl=1), point_count
// and the edge codes edge_0 to edge_3 (0 top, 1 right, 2 bottom, 3 left).
// ----------------------------------------------------------------------------
`include "threshold_marching_squares_macros.svh"

module threshold_marching_squares #(
	parameter int MAX_GRID_WIDTH = tms_pkg::MAX_GRID_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// Grid point input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
	// Square result output.
	output logic        m_tvalid,
	input  logic        m_tready,
	// square_x[9:0], square_y[19:10], case_index[23:20], point_count[26:24],
	// edge_0[28:27], edge_1[30:29], edge_2[32:31], edge_3[34:33], zero[39:35]
	output logic [39:0] m_tdata
);

	localparam int COL_W = $clog2(MAX_GRID_WIDTH);
	localparam int WW    = $clog2(MAX_GRID_WIDTH + 1);
	localparam int CMP_W = (WW > 11) ? WW : 11;

	// Configuration registers.
	logic [1:0]  trace_mode_q;
	logic [7:0]  threshold_q;
	logic        invert_q;
	logic [10:0] grid_width_q;
	logic [10:0] grid_height_q;

	// Scan state.
	logic [COL_W-1:0] col_q;
	logic [9:0]       row_q;
	logic             above_left_q;
	logic             left_q;

	// Output register.
	logic                  out_valid_q;
	logic [9:0]            sq_x_q;
	logic [9:0]            sq_y_q;
	logic [3:0]            case_q;
	logic [2:0]            count_q;
	tms_pkg::edge_set_t    edges_q;

	logic             accept;
	logic [7:0]       red, green, blue, alpha;
	logic [17:0]      luma;
	logic [17:0]      luma_level;
	logic             hit;
	logic             cur;
	logic             above;
	logic [3:0]       cs;
	logic             produce;
	logic [CMP_W-1:0] width_eff;
	logic [CMP_W-1:0] col_plus;
	logic [10:0]      height_eff;
	logic [10:0]      row_plus;
	logic             col_wrap;
	logic [COL_W-1:0] col_next;
	logic [9:0]       row_next;
	logic [COL_W-1:0] rd_addr;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];
	assign alpha = s_tdata[31:24];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_mode_q  <= tms_pkg::MODE_ALPHA;
			threshold_q   <= 8'd128;
			invert_q      <= 1'b0;
			grid_width_q  <= 11'd2;
			grid_height_q <= 11'd2;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tms_pkg::CFG_TRACE_MODE:  trace_mode_q  <= cfg_data[1:0];
				tms_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_data[7:0];
				tms_pkg::CFG_INVERT:      invert_q      <= cfg_data[0];
				tms_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				tms_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Inside decision for the incoming point.
	assign luma = 18'(red) * 18'd299 + 18'(green) * 18'd587 + 18'(blue) * 18'd114;
	assign luma_level = 18'(threshold_q) * 18'd1000;

	always_comb begin
		unique case (trace_mode_q)
			tms_pkg::MODE_ALPHA: hit = alpha >= threshold_q;
			tms_pkg::MODE_LUMA:  hit = luma >= luma_level;
			default: hit = (red >= threshold_q) || (green >= threshold_q)
				|| (blue >= threshold_q);
		endcase
	end

	assign cur = hit ^ invert_q;

	// Square case from the four corners.
	assign cs = {above_left_q, above, cur, left_q};
	assign produce = (row_q != 10'd0) && (col_q != '0) && (cs != tms_pkg::CASE_EMPTY)
		&& (cs != tms_pkg::CASE_FULL);

	// Effective frame size and counter advance.
	always_comb begin
		if (CMP_W'(grid_width_q) < CMP_W'(2)) begin
			width_eff = CMP_W'(2);
		end else if (CMP_W'(grid_width_q) > CMP_W'(MAX_GRID_WIDTH)) begin
			width_eff = CMP_W'(MAX_GRID_WIDTH);
		end else begin
			width_eff = CMP_W'(grid_width_q);
		end
		if (grid_height_q < 11'd2) begin
			height_eff = 11'd2;
		end else if (grid_height_q > 11'(tms_pkg::GRID_HEIGHT_MAX)) begin
			height_eff = 11'(tms_pkg::GRID_HEIGHT_MAX);
		end else begin
			height_eff = grid_height_q;
		end
	end

	assign col_plus = CMP_W'(col_q) + CMP_W'(1);
	assign row_plus = 11'(row_q) + 11'd1;
	assign col_wrap = col_plus >= width_eff;

	always_comb begin
		if (col_wrap) begin
			col_next = '0;
			row_next = (row_plus >= height_eff) ? 10'd0 : row_plus[9:0];
		end else begin
			col_next = col_plus[COL_W-1:0];
			row_next = row_q;
		end
	end

	// Read one column ahead so the bit above is ready at the next point.
	assign rd_addr = accept ? col_next : col_q;

	tms_ram #(
		.WIDTH (1),
		.DEPTH (MAX_GRID_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (cur),
		.rd_addr (rd_addr),
		.rd_data (above)
	);

	// Scan position and neighbor bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= 10'd0;
			above_left_q <= 1'b0;
			left_q       <= 1'b0;
		end else if (accept) begin
			col_q        <= col_next;
			row_q        <= row_next;
			above_left_q <= above;
			left_q       <= cur;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= produce;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			sq_x_q  <= 10'(col_q - COL_W'(1));
			sq_y_q  <= row_q - 10'd1;
			case_q  <= cs;
			count_q <= ((cs == tms_pkg::CASE_SADDLE_A) || (cs == tms_pkg::CASE_SADDLE_B))
				? tms_pkg::COUNT_SADDLE : tms_pkg::COUNT_PAIR;
			edges_q <= tms_pkg::edge_lookup(cs);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, edges_q, count_q, case_q, sq_y_q, sq_x_q};

	// A stalled result blocks the input side.
	`TMS_ASSERT_SAME(a_stall_blocks, out_valid_q && !m_tready, !s_tready, "accept while stalled")
	// A point in the first column never closes a square.
	`TMS_ASSERT_NEXT(a_first_col, accept && (col_q == '0), !out_valid_q, "result at column 0")
	// Uniform squares are never reported.
	`TMS_ASSERT_SAME(a_mixed_case, out_valid_q,
		(case_q != tms_pkg::CASE_EMPTY) && (case_q != tms_pkg::CASE_FULL), "uniform case out")
	// The edge count is COUNT_SADDLE exactly for the saddle cases.
	`TMS_ASSERT_SAME(a_saddle_count, out_valid_q,
		(count_q == tms_pkg::COUNT_SADDLE) == ((case_q == tms_pkg::CASE_SADDLE_A)
		|| (case_q == tms_pkg::CASE_SADDLE_B)), "edge count mismatch")
	// The column counter stays inside the line store.
	`TMS_ASSERT_SAME(a_col_range, accept, CMP_W'(col_q) < CMP_W'(MAX_GRID_WIDTH),
		"column beyond line store")

endmodule
